/* sv/sgci_pkg.sv */
package sgci_pkg;

  localparam int SgciSlots      = 4;
  localparam int SgciPlayersDef = 4;

  localparam int DIAL_W  = 8;
  localparam int SW_W    = 4;
  localparam int GEAR_W  = 3;
  localparam int LEVEL_W = 4;
  localparam int SEL_W   = 3;
  localparam int DATA_W  = 8;

  localparam logic [GEAR_W-1:0] GEAR_RESET = GEAR_W'(1);

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_READ   = 2'd1,
    REQ_WRITE  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  // Comparator results of one player.
  typedef struct packed {
    logic lever;
    logic wheel;
  } cmp_bits_t;

endpackage

/* sv/sgci_player.sv */
module sgci_player (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              sample_en,
  input  logic [sgci_pkg::DIAL_W-1:0]       dial,
  input  logic [sgci_pkg::SW_W-1:0]         sw,
  input  logic [sgci_pkg::LEVEL_W-1:0]      level,
  output sgci_pkg::cmp_bits_t               cmp
);

  logic [sgci_pkg::DIAL_W-1:0] last_dial_r, last_dial_nxt;
  logic                        dial_half_r, dial_half_nxt;
  logic                        turn_dir_r,  turn_dir_nxt;
  logic [sgci_pkg::GEAR_W-1:0] gear_r,      gear_nxt;
  logic [sgci_pkg::DIAL_W-1:0] diff;
  logic [1:0]                  wheel_sum;

  assign diff = dial - last_dial_r;

  always_comb begin
    last_dial_nxt = last_dial_r;
    dial_half_nxt = dial_half_r;
    turn_dir_nxt  = turn_dir_r;
    gear_nxt      = gear_r;
    if (sample_en) begin
      last_dial_nxt = dial;
      dial_half_nxt = dial[4];
      // a difference of exactly half a turn counts as negative
      if (diff != '0) begin
        turn_dir_nxt = ~diff[sgci_pkg::DIAL_W-1];
      end
      priority if (sw[3]) begin
        gear_nxt = sgci_pkg::GEAR_W'(4);
      end else if (sw[2]) begin
        gear_nxt = sgci_pkg::GEAR_W'(3);
      end else if (sw[1]) begin
        gear_nxt = sgci_pkg::GEAR_W'(2);
      end else if (sw[0]) begin
        gear_nxt = sgci_pkg::GEAR_W'(1);
      end else begin
        gear_nxt = gear_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dial_r <= '0;
      dial_half_r <= 1'b0;
      turn_dir_r  <= 1'b0;
      gear_r      <= sgci_pkg::GEAR_RESET;
    end else begin
      last_dial_r <= last_dial_nxt;
      dial_half_r <= dial_half_nxt;
      turn_dir_r  <= turn_dir_nxt;
      gear_r      <= gear_nxt;
    end
  end

  // Compare against the state as it stands after this transfer.
  assign wheel_sum = {1'b0, dial_half_nxt} + {1'b0, turn_dir_nxt};
  assign cmp.wheel = {wheel_sum, 3'b000} > {1'b0, level};
  assign cmp.lever = {gear_nxt, 2'b00} > {1'b0, level};

  a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
    (gear_r != '0) && (gear_r <= sgci_pkg::GEAR_W'(4)))
    else $error("gear out of range");

  a_dir_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!sample_en || (diff == '0)) |=> $stable(turn_dir_r))
    else $error("direction changed without a dial move");

endmodule

/* sv/steering_gear_comparator_inputs_top.sv */
// Path: a result passes the input register, then the result register, and is
//   presented from the latter; a new item is taken while a result waits.
// Throughput: one item per cycle while the output does not stall.
// Reset: synchronous active-low rst_n clears valids, dial state, direction
//   flops and comparator level, and sets every gear to 1.
module steering_gear_comparator_inputs_top #(
  parameter int PLAYERS = sgci_pkg::SgciPlayersDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_wheel_positions,
  input  logic [15:0] in_lever_switches,
  input  logic [2:0]  in_bit_select,
  input  logic [7:0]  in_latch_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic [7:0]  out_analog_byte
);

  localparam int Slots = sgci_pkg::SgciSlots;

  // Input register stage
  logic                          in_valid_r;
  sgci_pkg::req_t                req_r;
  logic [31:0]                   wheel_r;
  logic [15:0]                   lever_r;
  logic [sgci_pkg::SEL_W-1:0]    sel_r;
  logic [sgci_pkg::LEVEL_W-1:0]  latch_r;

  // Result register stage
  logic                          out_valid_r;
  logic [sgci_pkg::DATA_W-1:0]   read_data_r, read_data_nxt;
  logic [sgci_pkg::DATA_W-1:0]   analog_r;

  logic [sgci_pkg::LEVEL_W-1:0]  level_r, level_nxt;
  logic                          advance;
  logic                          in_xfer;
  logic                          sample_en;
  logic [2*Slots-1:0]            cmp_byte;

  // Move an item into the result register whenever that register is free
  // or drained this cycle; the input register refills in the same cycle.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  // Payload: hold while stalled, load on transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r   <= sgci_pkg::req_t'(in_req_type);
      wheel_r <= in_wheel_positions;
      lever_r <= in_lever_switches;
      sel_r   <= in_bit_select;
      latch_r <= in_latch_value[sgci_pkg::LEVEL_W-1:0];
    end
  end

  // Write request loads the shared comparator level.
  assign level_nxt = (advance && (req_r == sgci_pkg::REQ_WRITE)) ? latch_r : level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else begin
      level_r <= level_nxt;
    end
  end

  assign sample_en = advance && (req_r == sgci_pkg::REQ_SAMPLE);

  // One state slice per player; unused slots read as zero.
  for (genvar n = 0; n < Slots; n++) begin : g_player
    if (n < PLAYERS) begin : g_on
      sgci_pkg::cmp_bits_t cmp;
      sgci_player u_player (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_en (sample_en),
        .dial      (wheel_r[8*n +: sgci_pkg::DIAL_W]),
        .sw        (lever_r[4*n +: sgci_pkg::SW_W]),
        .level     (level_nxt),
        .cmp       (cmp)
      );
      assign cmp_byte[2*n]   = cmp.wheel;
      assign cmp_byte[2*n+1] = cmp.lever;
    end else begin : g_off
      assign cmp_byte[2*n +: 2] = 2'b00;
    end
  end

  // A read changes no state, so the post-step byte is the byte to read.
  always_comb begin
    read_data_nxt = '0;
    if (req_r == sgci_pkg::REQ_READ) begin
      read_data_nxt[sgci_pkg::DATA_W-1] = cmp_byte[sel_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data_r <= read_data_nxt;
      analog_r    <= cmp_byte;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = read_data_r;
  assign out_analog_byte = analog_r;

  a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && (req_r == sgci_pkg::REQ_WRITE)) |=> $stable(level_r))
    else $error("comparator level changed without a write");

  a_advance_valid: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result lost after advance");

  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (read_data_r[sgci_pkg::DATA_W-2:0] == '0))
    else $error("read data low bits not zero");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(req_r) && $stable(sel_r)))
    else $error("stalled input item lost");

endmodule

/* tb/steering_gear_comparator_inputs_top_tb.sv */
module steering_gear_comparator_inputs_top_tb;
  import sgci_pkg::*;

  localparam int NUM_PLAYERS   = SgciPlayersDef;
  localparam int RANDOM_ITEMS  = 1250;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int REPORT_MAX    = 10;

  // One expected result: the read byte and the full comparator byte.
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] analog_byte;
  } port_bytes_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_req_type = REQ_NONE;
  logic [31:0]       in_wheel_positions = '0;
  logic [15:0]       in_lever_switches = '0;
  logic [2:0]        in_bit_select = '0;
  logic [7:0]        in_latch_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_read_data;
  logic [7:0]        out_analog_byte;

  // Mirror of the block's state.
  logic [DIAL_W-1:0]  dial_seen [SgciSlots];
  logic               half_bit  [SgciSlots];
  logic               dir_bit   [SgciSlots];
  logic [GEAR_W-1:0]  gear_sel  [SgciSlots];
  logic [LEVEL_W-1:0] level_cur;

  port_bytes_t result_q[$];
  int          mismatch_count = 0;
  int          result_count = 0;
  int          req_count [4];
  int          burst_left = 0;
  int          idle_cycles = 0;

  steering_gear_comparator_inputs_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_wheel_positions (in_wheel_positions),
    .in_lever_switches  (in_lever_switches),
    .in_bit_select      (in_bit_select),
    .in_latch_value     (in_latch_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_analog_byte    (out_analog_byte)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Comparator bits from the mirrored state: wheel at bit 2n, lever at 2n+1.
  function automatic logic [DATA_W-1:0] comparator_byte();
    logic [DATA_W-1:0] b;
    int                wheel;
    int                lever;
    b = '0;
    for (int n = 0; n < NUM_PLAYERS && n < SgciSlots; n++) begin
      wheel = 8 * half_bit[n] + 8 * dir_bit[n];
      lever = 4 * gear_sel[n];
      if (wheel > level_cur) b[2*n] = 1'b1;
      if (lever > level_cur) b[2*n+1] = 1'b1;
    end
    return b;
  endfunction

  // Advance the mirrored state by one request and return what the block owes.
  function automatic port_bytes_t apply_request(req_t rt, logic [31:0] wheels,
                                                logic [15:0] levers, logic [2:0] sel,
                                                logic [7:0] latch);
    port_bytes_t       r;
    logic [DATA_W-1:0] cmp;
    logic [DIAL_W-1:0] dial;
    logic [DIAL_W-1:0] diff;
    logic [SW_W-1:0]   sw;
    r.read_data = '0;
    case (rt)
      REQ_SAMPLE: begin
        for (int n = 0; n < NUM_PLAYERS && n < SgciSlots; n++) begin
          dial = wheels[8*n +: 8];
          sw   = levers[4*n +: 4];
          diff = dial - dial_seen[n];
          // Zero difference keeps the direction; 0x80 counts as negative.
          if (diff != '0) dir_bit[n] = ~diff[7];
          half_bit[n] = dial[4];
          // Highest switch wins; no switch holds the gear.
          if (sw[3])      gear_sel[n] = 3'd4;
          else if (sw[2]) gear_sel[n] = 3'd3;
          else if (sw[1]) gear_sel[n] = 3'd2;
          else if (sw[0]) gear_sel[n] = 3'd1;
          dial_seen[n] = dial;
        end
      end
      REQ_READ: begin
        cmp = comparator_byte();
        r.read_data = {cmp[sel], 7'b0};
      end
      REQ_WRITE: level_cur = latch[LEVEL_W-1:0];
      default: ;
    endcase
    r.analog_byte = comparator_byte();
    return r;
  endfunction

  // Send one item in a sender burst; open a random gap when a burst runs out.
  task automatic send_item(req_t rt, logic [31:0] wheels, logic [15:0] levers,
                           logic [2:0] sel, logic [7:0] latch);
    int gap;
    if (burst_left == 0) begin
      // A third of the bursts follow back to back with no gap.
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) @(negedge clk) in_valid <= 1'b0;
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid           <= 1'b1;
    in_req_type        <= rt;
    in_wheel_positions <= wheels;
    in_lever_switches  <= levers;
    in_bit_select      <= sel;
    in_latch_value     <= latch;
    // Hold the item until the block takes it.
    do @(posedge clk); while (!in_ready);
    result_q.push_back(apply_request(rt, wheels, levers, sel, latch));
    req_count[rt]++;
  endtask

  // Receiver: switch between always ready, coin-flip stalls and a repeating pattern.
  initial begin
    int          mode;
    int          span;
    logic [7:0]  pat;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 200);
      pat  = 8'($urandom) | 8'h01;
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom);
          default: begin
            out_ready <= pat[0];
            pat = {pat[0], pat[7:1]};
          end
        endcase
      end
    end
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    port_bytes_t want;
    if (rst_n && out_valid && out_ready) begin
      result_count++;
      if (result_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result: read_data=%h analog_byte=%h",
                   out_read_data, out_analog_byte);
      end else begin
        want = result_q.pop_front();
        if (out_read_data !== want.read_data) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("read_data mismatch: expected %h, got %h",
                     want.read_data, out_read_data);
        end
        if (out_analog_byte !== want.analog_byte) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("analog_byte mismatch: expected %h, got %h",
                     want.analog_byte, out_analog_byte);
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer in %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Reset values, the no-op request and reads of bits 0 and 7.
  task automatic test_reset_state();
    send_item(REQ_NONE, 32'hFFFF_FFFF, 16'hFFFF, 3'd7, 8'hFF);
    send_item(REQ_READ, 32'h0, 16'h0, 3'd0, 8'h0);
    send_item(REQ_READ, 32'h0, 16'h0, 3'd7, 8'h0);
  endtask

  // Level extremes; write data above the low nibble must drop out.
  task automatic test_level_extremes();
    send_item(REQ_WRITE, 32'hFFFF_FFFF, 16'hFFFF, 3'd7, 8'hFF);
    send_item(REQ_READ, 32'h0, 16'h0, 3'd1, 8'h0);
    send_item(REQ_WRITE, 32'h0, 16'h0, 3'd0, 8'hF0);
    send_item(REQ_READ, 32'h0, 16'h0, 3'd1, 8'h0);
  endtask

  // Positive, negative, zero and 0x80 dial steps, plus the count's bit 4.
  task automatic test_dial_direction();
    send_item(REQ_SAMPLE, 32'h80_7F_01_00, 16'h0, 3'd0, 8'h0);
    send_item(REQ_WRITE, 32'h0, 16'h0, 3'd0, 8'h08);
    send_item(REQ_SAMPLE, 32'h00_FF_00_FF, 16'h0, 3'd0, 8'h0);
    send_item(REQ_SAMPLE, 32'h10_EF_10_10, 16'h0, 3'd0, 8'h0);
    send_item(REQ_SAMPLE, 32'h10_EF_10_10, 16'h0, 3'd0, 8'h0);
    send_item(REQ_READ, 32'h0, 16'h0, 3'd6, 8'h0);
  endtask

  // Single switches, none set, all set and mixed nibbles.
  task automatic test_gear_switches();
    send_item(REQ_WRITE, 32'h0, 16'h0, 3'd0, 8'h0B);
    send_item(REQ_SAMPLE, 32'h10_EF_10_10, 16'h8421, 3'd0, 8'h0);
    send_item(REQ_SAMPLE, 32'h10_EF_10_10, 16'h0000, 3'd0, 8'h0);
    send_item(REQ_SAMPLE, 32'h10_EF_10_10, 16'hFFFF, 3'd0, 8'h0);
    send_item(REQ_SAMPLE, 32'h10_EF_10_10, 16'h1357, 3'd0, 8'h0);
    send_item(REQ_READ, 32'h0, 16'h0, 3'd3, 8'h0);
    send_item(REQ_WRITE, 32'h0, 16'h0, 3'd0, 8'h0C);
    send_item(REQ_READ, 32'h0, 16'h0, 3'd5, 8'h0);
  endtask

  // Random mix; dials mostly step near the last count so that zero and
  // small differences and the 0x80 step turn up often.
  task automatic test_random_traffic();
    int          pick;
    req_t        rt;
    logic [31:0] wheels;
    logic [7:0]  d;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)      rt = REQ_SAMPLE;
      else if (pick < 72) rt = REQ_READ;
      else if (pick < 92) rt = REQ_WRITE;
      else                rt = REQ_NONE;
      for (int n = 0; n < SgciSlots; n++) begin
        case ($urandom_range(0, 4))
          0:       d = dial_seen[n];
          1:       d = dial_seen[n] + 8'h80;
          2:       d = dial_seen[n] + 8'($urandom_range(1, 20));
          3:       d = dial_seen[n] - 8'($urandom_range(1, 20));
          default: d = 8'($urandom);
        endcase
        wheels[8*n +: 8] = d;
      end
      // Reads and writes carry random noise in the fields they ignore.
      if (rt != REQ_SAMPLE && $urandom_range(0, 1)) wheels = $urandom;
      send_item(rt, wheels, 16'($urandom), 3'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    for (int n = 0; n < SgciSlots; n++) begin
      dial_seen[n] = '0;
      half_bit[n]  = 1'b0;
      dir_bit[n]   = 1'b0;
      gear_sel[n]  = GEAR_RESET;
    end
    level_cur = '0;
    for (int k = 0; k < 4; k++) req_count[k] = 0;

    // Hold reset, then release it on a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_reset_state();
    test_level_extremes();
    test_dial_direction();
    test_gear_switches();
    test_random_traffic();

    @(negedge clk) in_valid <= 1'b0;
    // Drain outstanding results, then allow the pipeline to settle.
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d samples, %0d reads, %0d level writes, %0d no-op requests",
             req_count[REQ_SAMPLE], req_count[REQ_READ], req_count[REQ_WRITE],
             req_count[REQ_NONE]);
    $display("checked %0d results, %0d mismatches", result_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/sgci_pkg.sv
sv/sgci_player.sv
sv/steering_gear_comparator_inputs_top.sv
tb/steering_gear_comparator_inputs_top_tb.sv
